// File: hdl/byteps_pkg.sv
package byteps_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int BUF_MAX     = 8388608;

	localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W  = 7;
	localparam int ADDR_W = 23;
	localparam int CNT_W  = $clog2(BUF_MAX + 1);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	localparam logic MODE_ANY   = 1'b0;
	localparam logic MODE_FIXED = 1'b1;

	typedef enum logic [1:0] {
		CFG_PATTERN_LENGTH = 2'd0,
		CFG_SEARCH_MODE    = 2'd1,
		CFG_MATCH_ADDRESS  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_ALIGN
	} align_state_t;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  pattern_index;
		logic [7:0]  data_byte;
		logic        last_byte;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_position;
	} res_t;

	typedef struct packed {
		logic take;
		logic align_shift;
	} cell_ctrl_t;

endpackage

// File: hdl/byteps_ram.sv
module byteps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/byteps_cell.sv
module byteps_cell (
	input  logic                   clk,
	input  byteps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]             byte_in,
	input  logic [7:0]             ref_in,
	input  logic                   ref_we,
	input  logic [7:0]             ref_wdata,
	output logic [7:0]             byte_out,
	output logic [7:0]             ref_out,
	output logic                   eq
);

	logic [7:0] recent_q;
	logic [7:0] ref_q;

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			recent_q <= byte_in;
		end
		if (ctrl.align_shift) begin
			ref_q <= ref_in;
		end else if (ref_we) begin
			ref_q <= ref_wdata;
		end
	end

	assign byte_out = recent_q;
	assign ref_out  = ref_q;
	assign eq       = (recent_q == ref_q);

endmodule

// File: hdl/byte_pattern_search.sv
// Byte pattern search over a streamed buffer.
// Request channel (req_valid/req_stall/req): req_type REQ_LOAD writes one
// pattern byte at pattern_index, REQ_BYTE delivers one buffer byte. Both kinds
// transfer at one per cycle when not stalled. A buffer byte with last_byte
// set yields one result on the response channel (res_valid/res_stall/res):
// found and the start of the first match (fixed-address mode: match_address
// itself). The last byte passes the s1 stage registers, then sets res_valid.
// A last byte is held off while an earlier result is still waiting or about
// to be loaded; other bytes keep flowing while res is stalled, and res holds.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready.
// A write of pattern_length from 1 to 64 rebuilds the compare row of cells
// from the pattern RAM, one byte per cycle: req_stall is high until the
// last byte read from the RAM has been shifted into the row.
// Each cell holds one recent buffer byte and the pattern byte aligned to it;
// all cells compare in parallel the cycle after a byte arrives.
// Reset: pattern_length 1, anywhere mode, match_address 0, stream state
// cleared, no result pending. Pattern bytes are undefined until loaded;
// there is no clearing pass.
module byte_pattern_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  byteps_pkg::req_t                    req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output byteps_pkg::res_t                    res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [byteps_pkg::ADDR_W-1:0]       cfg_data
);

	localparam int N = byteps_pkg::PATTERN_MAX;

	// configuration
	logic [byteps_pkg::LEN_W-1:0]  len_q;
	logic                          mode_q;
	logic [byteps_pkg::ADDR_W-1:0] addr_q;

	// compare-row rebuild
	byteps_pkg::align_state_t      state_q, state_d;
	logic [byteps_pkg::PIDX_W-1:0] cnt_q;
	logic                          rd_valid_q;
	logic                          issue;
	logic                          busy;

	// stream state
	logic [byteps_pkg::CNT_W-1:0]  bytes_seen_q;
	logic                          match_seen_q;
	logic [byteps_pkg::ADDR_W-1:0] first_start_q;

	logic                          s1_valid_s1;
	logic                          s1_take_s1;
	logic                          s1_last_s1;
	logic [byteps_pkg::CNT_W-1:0]  s1_cnt_s1;

	logic                          res_valid_q;
	byteps_pkg::res_t              res_q;

	logic                          cfg_wr;
	logic                          len_wr;
	logic [byteps_pkg::LEN_W-1:0]  new_len;
	logic                          new_len_ok;
	logic                          len_ok;
	logic                          req_acc;
	logic                          byte_acc;
	logic                          load_acc;
	logic                          take;
	logic                          ram_we;
	logic                          ref_load;
	logic [byteps_pkg::LEN_W-1:0]  ref_slot;
	logic [7:0]                    ram_rdata;

	byteps_pkg::cell_ctrl_t        ctrl;
	logic [7:0]                    recent [N];
	logic [7:0]                    refb   [N];
	logic [N-1:0]                  eq_vec;
	logic [N-1:0]                  mask;
	logic [N-1:0]                  ref_we;

	logic                          all_eq;
	logic                          hit;
	logic [byteps_pkg::CNT_W-1:0]  start;
	logic                          qual;
	logic                          ms_next;
	logic [byteps_pkg::ADDR_W-1:0] fs_next;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid & cfg_ready;
	assign len_wr     = cfg_wr && (cfg_index == byteps_pkg::CFG_PATTERN_LENGTH);
	assign new_len    = cfg_data[byteps_pkg::LEN_W-1:0];
	assign new_len_ok = (new_len != '0) && (int'(new_len) <= N);
	assign len_ok     = (len_q != '0) && (int'(len_q) <= N);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= byteps_pkg::LEN_W'(1);
			mode_q <= byteps_pkg::MODE_ANY;
			addr_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				byteps_pkg::CFG_PATTERN_LENGTH: len_q  <= new_len;
				byteps_pkg::CFG_SEARCH_MODE:    mode_q <= cfg_data[0];
				byteps_pkg::CFG_MATCH_ADDRESS:  addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			byteps_pkg::ST_IDLE: begin
				if (len_wr && new_len_ok) begin
					state_d = byteps_pkg::ST_ALIGN;
				end
			end
			byteps_pkg::ST_ALIGN: begin
				if (len_wr) begin
					state_d = new_len_ok ? byteps_pkg::ST_ALIGN : byteps_pkg::ST_IDLE;
				end else if (int'(cnt_q) == int'(len_q) - 1) begin
					state_d = byteps_pkg::ST_IDLE;
				end
			end
			default: state_d = byteps_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			byteps_pkg::ST_IDLE:  issue = 1'b0;
			byteps_pkg::ST_ALIGN: issue = 1'b1;
			default:              issue = 1'b0;
		endcase
	end

	assign busy = (state_q != byteps_pkg::ST_IDLE) | rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= byteps_pkg::ST_IDLE;
			cnt_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= issue;
			if (len_wr) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + byteps_pkg::PIDX_W'(1);
			end
		end
	end

	// request side
	assign req_stall = busy | ((req.req_type == byteps_pkg::REQ_BYTE) && req.last_byte &&
		(res_valid_q || (s1_valid_s1 && s1_last_s1)));
	assign req_acc   = req_valid & ~req_stall;
	assign byte_acc  = req_acc && (req.req_type == byteps_pkg::REQ_BYTE);
	assign load_acc  = req_acc && (req.req_type == byteps_pkg::REQ_LOAD);
	assign take      = byte_acc && (bytes_seen_q < byteps_pkg::CNT_W'(byteps_pkg::BUF_MAX));
	assign ram_we    = load_acc && (int'(req.pattern_index) < N);
	assign ref_load  = ram_we && len_ok && (int'(req.pattern_index) < int'(len_q));
	assign ref_slot  = len_q - byteps_pkg::LEN_W'(1) - byteps_pkg::LEN_W'(req.pattern_index);

	byteps_ram #(
		.WIDTH(8),
		.DEPTH(N)
	) u_pattern_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(byteps_pkg::PIDX_W'(req.pattern_index)),
		.wdata(req.data_byte),
		.re   (issue),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	assign ctrl.take        = take;
	assign ctrl.align_shift = rd_valid_q;

	for (genvar j = 0; j < N; j++) begin : g_cell
		assign ref_we[j] = ref_load && (int'(ref_slot) == j);
		assign mask[j]   = int'(len_q) > j;

		byteps_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.byte_in  ((j == 0) ? req.data_byte : recent[(j == 0) ? 0 : j - 1]),
			.ref_in   ((j == 0) ? ram_rdata : refb[(j == 0) ? 0 : j - 1]),
			.ref_we   (ref_we[j]),
			.ref_wdata(req.data_byte),
			.byte_out (recent[j]),
			.ref_out  (refb[j]),
			.eq       (eq_vec[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			s1_valid_s1  <= 1'b0;
		end else begin
			s1_valid_s1 <= byte_acc;
			if (byte_acc && req.last_byte) begin
				bytes_seen_q <= '0;
			end else if (take) begin
				bytes_seen_q <= bytes_seen_q + byteps_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			s1_take_s1 <= take;
			s1_last_s1 <= req.last_byte;
			s1_cnt_s1  <= bytes_seen_q + byteps_pkg::CNT_W'(1);
		end
	end

	// window check for the byte taken last cycle
	assign all_eq = &(eq_vec | ~mask);
	assign start  = s1_cnt_s1 - byteps_pkg::CNT_W'(len_q);
	assign hit    = s1_valid_s1 && s1_take_s1 && len_ok &&
		(s1_cnt_s1 >= byteps_pkg::CNT_W'(len_q)) && all_eq;

	always_comb begin
		if (mode_q == byteps_pkg::MODE_FIXED) begin
			qual = hit && (start[byteps_pkg::ADDR_W-1:0] == addr_q) &&
				(start[byteps_pkg::CNT_W-1:byteps_pkg::ADDR_W] == '0);
		end else begin
			qual = hit && !match_seen_q;
		end
		ms_next = match_seen_q | qual;
		fs_next = qual ? start[byteps_pkg::ADDR_W-1:0] : first_start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q  <= 1'b0;
			first_start_q <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (s1_valid_s1 && s1_last_s1) begin
				match_seen_q  <= 1'b0;
				first_start_q <= '0;
				res_valid_q   <= 1'b1;
			end else begin
				match_seen_q  <= ms_next;
				first_start_q <= fs_next;
				if (!res_stall) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && s1_last_s1) begin
			res_q.found          <= ms_next;
			res_q.match_position <= ms_next ? fs_next : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_no_take_while_align: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != byteps_pkg::ST_IDLE) |-> req_stall)
		else $error("request taken while compare row is rebuilt");

	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_valid_s1 && s1_last_s1))
		else $error("result raised without a last byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && s1_last_s1) |-> !res_valid_q)
		else $error("result register still full when a new result arrives");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_acc && req.last_byte) |=> (bytes_seen_q == '0))
		else $error("byte count not cleared after last byte");

endmodule
